FILE: design/nsp_pkg.sv
// Shared types, codes and widths for the nearest segment projector.
package nsp_pkg;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam int unsigned BASE_LIMIT_METRES = 10000000;

    // Quotient of one foot offset never exceeds |d| < 2^32.
    localparam int Q_BITS    = 33;
    localparam int NUM_W     = 100;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] coord_ax;
        logic signed [31:0] coord_ay;
        logic signed [31:0] coord_bx;
        logic signed [31:0] coord_by;
    } nsp_req_t;

    typedef struct packed {
        logic               found;
        logic [9:0]         segment_index;
        logic signed [31:0] foot_x;
        logic signed [31:0] foot_y;
        logic [62:0]        distance_sq;
    } nsp_rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_QUERY_INIT,
        OP_MUL_LIM,
        OP_LIM_SET,
        OP_READ,
        OP_SETUP,
        OP_MUL_DXDX,
        OP_MUL_DYDY,
        OP_MUL_WXDX,
        OP_MUL_WYDY,
        OP_LEN_SET,
        OP_LEN_ADD,
        OP_DOT_SET,
        OP_DOT_ADD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_NUM_SET,
        OP_NUM_ADD,
        OP_NUM_FIN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FOOT,
        OP_ERR,
        OP_MUL_EXEX,
        OP_MUL_EYEY,
        OP_DSQ_SET,
        OP_DSQ_ADD,
        OP_UPDATE,
        OP_NEXT,
        OP_RESULT
    } nsp_op_t;

    typedef struct packed {
        nsp_op_t op;
        logic    axis;   // 0: x, 1: y
    } nsp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic zero_len;
        logic off_seg;
        logic div_last;
    } nsp_status_t;

endpackage

FILE: design/nsp_datapath.sv
// Datapath: segment memory, shared multiplier, restoring divider, best-match tracking.
module nsp_datapath
    import nsp_pkg::*;
#(
    parameter int          MAX_SEGMENTS = 1024,
    parameter logic [31:0] LIMIT_RESET  = 32'hFFFFFFFF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  nsp_req_t    request,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  nsp_cmd_t    cmd,
    output nsp_status_t status,
    output logic        done,
    output nsp_rsp_t    result
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic [127:0] seg_mem [MAX_SEGMENTS];
    logic [127:0] rd_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] j_reg;
    logic [31:0]      limit_reg;
    logic [63:0]      lim2_reg;

    logic signed [31:0] px_reg, py_reg, ax_reg, ay_reg;
    logic signed [32:0] dx_reg, dy_reg, wx_reg, wy_reg, ex_reg, ey_reg;
    logic signed [69:0] prod_reg;
    logic [66:0]        len_reg;
    logic signed [67:0] dot_reg;
    logic [NUM_W-1:0]   num_reg, divd_reg;
    logic [Q_BITS-1:0]  q_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic signed [31:0] fx_reg, fy_reg;
    logic [67:0]        dsq_reg;

    logic               have_reg;
    logic [67:0]        best_reg;
    logic [CNT_W-1:0]   best_idx_reg;
    logic signed [31:0] best_fx_reg, best_fy_reg;

    logic     done_reg;
    nsp_rsp_t result_reg;

    logic signed [31:0] m_ax, m_ay, m_bx, m_by;
    logic               full;
    logic signed [34:0] mul_a, mul_b;
    logic signed [32:0] d_axis;
    logic               d_neg;
    logic [32:0]        d_mag;
    logic signed [33:0] off;
    logic signed [33:0] foot;
    logic               take;

    assign m_ax = rd_reg[127:96];
    assign m_ay = rd_reg[95:64];
    assign m_bx = rd_reg[63:32];
    assign m_by = rd_reg[31:0];
    assign full = (count_reg == CNT_W'(MAX_SEGMENTS));

    assign d_axis = cmd.axis ? dy_reg : dx_reg;
    assign d_neg  = d_axis[32];
    assign d_mag  = d_neg ? 33'(-d_axis) : 33'(d_axis);
    assign off    = d_neg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign foot   = (cmd.axis ? {{2{ay_reg[31]}}, ay_reg} : {{2{ax_reg[31]}}, ax_reg}) + off;
    assign take   = (dsq_reg < {4'b0, lim2_reg}) && (!have_reg || dsq_reg < best_reg);

    assign status.scan_done = (j_reg == count_reg);
    assign status.zero_len  = (m_bx == m_ax) && (m_by == m_ay);
    assign status.off_seg   = dot_reg[67] || (dot_reg[66:0] > len_reg);
    assign status.div_last  = (div_cnt_reg == '0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_LIM:
            begin
                mul_a = $signed({3'b0, limit_reg});
                mul_b = $signed({3'b0, limit_reg});
            end
            OP_MUL_DXDX:
            begin
                mul_a = 35'(dx_reg);
                mul_b = 35'(dx_reg);
            end
            OP_MUL_DYDY:
            begin
                mul_a = 35'(dy_reg);
                mul_b = 35'(dy_reg);
            end
            OP_MUL_WXDX:
            begin
                mul_a = 35'(wx_reg);
                mul_b = 35'(dx_reg);
            end
            OP_MUL_WYDY:
            begin
                mul_a = 35'(wy_reg);
                mul_b = 35'(dy_reg);
            end
            OP_MUL_LO:
            begin
                mul_a = $signed({1'b0, dot_reg[33:0]});
                mul_b = $signed({2'b0, d_mag});
            end
            OP_MUL_HI:
            begin
                mul_a = $signed({2'b0, dot_reg[66:34]});
                mul_b = $signed({2'b0, d_mag});
            end
            OP_MUL_EXEX:
            begin
                mul_a = 35'(ex_reg);
                mul_b = 35'(ex_reg);
            end
            OP_MUL_EYEY:
            begin
                mul_a = 35'(ey_reg);
                mul_b = 35'(ey_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // segment memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && !full)
        begin
            seg_mem[count_reg[IDX_W-1:0]] <= {request.coord_ax, request.coord_ay,
                                              request.coord_bx, request.coord_by};
        end
        if (cmd.op == OP_READ)
        begin
            rd_reg <= seg_mem[j_reg[IDX_W-1:0]];
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.op)
            OP_QUERY_INIT:
            begin
                px_reg <= request.coord_ax;
                py_reg <= request.coord_ay;
            end
            OP_LIM_SET:  lim2_reg <= prod_reg[63:0];
            OP_SETUP:
            begin
                ax_reg <= m_ax;
                ay_reg <= m_ay;
                dx_reg <= {m_bx[31], m_bx} - {m_ax[31], m_ax};
                dy_reg <= {m_by[31], m_by} - {m_ay[31], m_ay};
                wx_reg <= {px_reg[31], px_reg} - {m_ax[31], m_ax};
                wy_reg <= {py_reg[31], py_reg} - {m_ay[31], m_ay};
            end
            OP_LEN_SET:  len_reg <= prod_reg[66:0];
            OP_LEN_ADD:  len_reg <= len_reg + prod_reg[66:0];
            OP_DOT_SET:  dot_reg <= prod_reg[67:0];
            OP_DOT_ADD:  dot_reg <= dot_reg + prod_reg[67:0];
            OP_NUM_SET:  num_reg <= {32'b0, prod_reg[67:0]};
            OP_NUM_ADD:  num_reg <= num_reg + {prod_reg[65:0], 34'b0};
            OP_NUM_FIN:  num_reg <= {num_reg[NUM_W-2:0], 1'b0} + {33'b0, len_reg};
            OP_DIV_INIT:
            begin
                divd_reg    <= {len_reg, 1'b0, 32'b0};
                q_reg       <= '0;
            end
            OP_DIV_STEP:
            begin
                if (num_reg >= divd_reg)
                begin
                    num_reg <= num_reg - divd_reg;
                    q_reg   <= {q_reg[Q_BITS-2:0], 1'b1};
                end
                else
                begin
                    q_reg   <= {q_reg[Q_BITS-2:0], 1'b0};
                end
                divd_reg <= {1'b0, divd_reg[NUM_W-1:1]};
            end
            OP_FOOT:
            begin
                if (cmd.axis)
                    fy_reg <= foot[31:0];
                else
                    fx_reg <= foot[31:0];
            end
            OP_ERR:
            begin
                ex_reg <= {px_reg[31], px_reg} - {fx_reg[31], fx_reg};
                ey_reg <= {py_reg[31], py_reg} - {fy_reg[31], fy_reg};
            end
            OP_DSQ_SET:  dsq_reg <= prod_reg[67:0];
            OP_DSQ_ADD:  dsq_reg <= dsq_reg + prod_reg[67:0];
            OP_UPDATE:
            begin
                if (take)
                begin
                    best_reg     <= dsq_reg;
                    best_idx_reg <= j_reg;
                    best_fx_reg  <= fx_reg;
                    best_fy_reg  <= fy_reg;
                end
            end
            OP_RESULT:
            begin
                if (have_reg)
                begin
                    result_reg.found         <= 1'b1;
                    result_reg.segment_index <= 10'(32'(best_idx_reg));
                    result_reg.foot_x        <= best_fx_reg;
                    result_reg.foot_y        <= best_fy_reg;
                    result_reg.distance_sq   <= (best_reg[67:63] != '0) ? '1
                                                                        : best_reg[62:0];
                end
                else
                begin
                    result_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            j_reg       <= '0;
            limit_reg   <= LIMIT_RESET;
            have_reg    <= 1'b0;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_RESULT);
            if (cfg_we)
                limit_reg <= cfg_wdata;
            unique case (cmd.op)
                OP_CLEAR:      count_reg <= '0;
                OP_LOAD:       if (!full) count_reg <= count_reg + 1'b1;
                OP_QUERY_INIT:
                begin
                    j_reg    <= '0;
                    have_reg <= 1'b0;
                end
                OP_DIV_INIT:   div_cnt_reg <= DIV_CNT_W'(Q_BITS - 1);
                OP_DIV_STEP:   div_cnt_reg <= div_cnt_reg - 1'b1;
                OP_UPDATE:     if (take) have_reg <= 1'b1;
                OP_NEXT:       j_reg <= j_reg + 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/nsp_controller.sv
// Controller: issues clear and load commands and sequences the per-segment projection steps of a query.
module nsp_controller
    import nsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  action,
    input  nsp_status_t status,
    output logic        busy,
    output nsp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LIM_MUL, ST_LIM_SET, ST_CHECK, ST_SETUP,
        ST_M_DXDX, ST_LEN_SET, ST_M_DYDY, ST_LEN_ADD,
        ST_M_WXDX, ST_DOT_SET, ST_M_WYDY, ST_DOT_ADD, ST_DOT_TEST,
        ST_M_LO, ST_NUM_SET, ST_M_HI, ST_NUM_ADD, ST_NUM_FIN,
        ST_DIV_INIT, ST_DIV_STEP, ST_FOOT,
        ST_ERR, ST_M_EXEX, ST_DSQ_SET, ST_M_EYEY, ST_DSQ_ADD, ST_UPDATE, ST_NEXT
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    nsp_op_t op;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_CLEAR: op = OP_CLEAR;
                        ACT_LOAD:  op = OP_LOAD;
                        ACT_QUERY:
                        begin
                            op         = OP_QUERY_INIT;
                            state_next = ST_LIM_MUL;
                        end
                        default:   op = OP_NONE;
                    endcase
                end
            end
            ST_LIM_MUL:  begin op = OP_MUL_LIM;  state_next = ST_LIM_SET; end
            ST_LIM_SET:  begin op = OP_LIM_SET;  state_next = ST_CHECK;   end
            ST_CHECK:
            begin
                if (status.scan_done)
                begin
                    op         = OP_RESULT;
                    state_next = ST_IDLE;
                end
                else
                begin
                    op         = OP_READ;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                op         = OP_SETUP;
                state_next = status.zero_len ? ST_NEXT : ST_M_DXDX;
            end
            ST_M_DXDX:   begin op = OP_MUL_DXDX; state_next = ST_LEN_SET; end
            ST_LEN_SET:  begin op = OP_LEN_SET;  state_next = ST_M_DYDY;  end
            ST_M_DYDY:   begin op = OP_MUL_DYDY; state_next = ST_LEN_ADD; end
            ST_LEN_ADD:  begin op = OP_LEN_ADD;  state_next = ST_M_WXDX;  end
            ST_M_WXDX:   begin op = OP_MUL_WXDX; state_next = ST_DOT_SET; end
            ST_DOT_SET:  begin op = OP_DOT_SET;  state_next = ST_M_WYDY;  end
            ST_M_WYDY:   begin op = OP_MUL_WYDY; state_next = ST_DOT_ADD; end
            ST_DOT_ADD:  begin op = OP_DOT_ADD;  state_next = ST_DOT_TEST; end
            ST_DOT_TEST:
            begin
                axis_next  = 1'b0;
                state_next = status.off_seg ? ST_NEXT : ST_M_LO;
            end
            ST_M_LO:     begin op = OP_MUL_LO;   state_next = ST_NUM_SET;  end
            ST_NUM_SET:  begin op = OP_NUM_SET;  state_next = ST_M_HI;     end
            ST_M_HI:     begin op = OP_MUL_HI;   state_next = ST_NUM_ADD;  end
            ST_NUM_ADD:  begin op = OP_NUM_ADD;  state_next = ST_NUM_FIN;  end
            ST_NUM_FIN:  begin op = OP_NUM_FIN;  state_next = ST_DIV_INIT; end
            ST_DIV_INIT: begin op = OP_DIV_INIT; state_next = ST_DIV_STEP; end
            ST_DIV_STEP:
            begin
                op = OP_DIV_STEP;
                if (status.div_last)
                    state_next = ST_FOOT;
            end
            ST_FOOT:
            begin
                op = OP_FOOT;
                if (axis_reg)
                    state_next = ST_ERR;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_M_LO;
                end
            end
            ST_ERR:      begin op = OP_ERR;      state_next = ST_M_EXEX;  end
            ST_M_EXEX:   begin op = OP_MUL_EXEX; state_next = ST_DSQ_SET; end
            ST_DSQ_SET:  begin op = OP_DSQ_SET;  state_next = ST_M_EYEY;  end
            ST_M_EYEY:   begin op = OP_MUL_EYEY; state_next = ST_DSQ_ADD; end
            ST_DSQ_ADD:  begin op = OP_DSQ_ADD;  state_next = ST_UPDATE;  end
            ST_UPDATE:   begin op = OP_UPDATE;   state_next = ST_NEXT;    end
            ST_NEXT:     begin op = OP_NEXT;     state_next = ST_CHECK;   end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign cmd.op   = op;
    assign cmd.axis = axis_reg;

endmodule

FILE: design/nearest_segment_projector.sv
// Top level of the nearest segment projector: controller plus datapath.
//
// Loads road segments into a table, one per request, and answers point queries
// with the nearest segment whose perpendicular foot lies on it. Clear and load
// requests finish in the cycle they are accepted, so busy never rises for them.
// A query holds busy while it scans the stored segments in order: zero-length
// ones are skipped after setup, those whose foot is off the segment are dropped
// after the dot-product test, and the rest are fully projected and checked
// against the distance limit. Every projected segment passes through one shared
// 35x35 multiplier and a 33-step restoring divider run once per axis. The result
// appears on result for exactly one cycle with done high, the first cycle with
// busy low again; the receiver cannot stall it, so it must be captured then.
// distance_limit is written through cfg_we/cfg_wdata and should only change
// while the block is idle.
module nearest_segment_projector
    import nsp_pkg::*;
#(
    parameter int MAX_SEGMENTS    = 1024,
    parameter int COORD_FRAC_BITS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  nsp_req_t    request,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        done,
    output nsp_rsp_t    result
);

    // reset limit: base metres scaled to fixed point, saturated to 32 bits
    localparam logic [63:0] LIMIT_FULL  = 64'(BASE_LIMIT_METRES) << COORD_FRAC_BITS;
    localparam logic [31:0] LIMIT_RESET = (LIMIT_FULL > 64'h0000_0000_FFFF_FFFF)
                                          ? 32'hFFFF_FFFF : LIMIT_FULL[31:0];

    nsp_cmd_t    cmd;
    nsp_status_t status;

    nsp_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    nsp_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .LIMIT_RESET  (LIMIT_RESET)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

    // a result only follows a busy cycle that issued it
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a running query");

    // one query gives one strobe
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe repeated");

    // a miss reports all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.segment_index == '0 && result.foot_x == '0
                                     && result.foot_y == '0 && result.distance_sq == '0))
        else $error("miss result carries nonzero fields");

    // busy falls exactly when the result is issued
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("query ended without a result");

endmodule

FILE: sim/nearest_segment_projector_checker.sv
// Checker for the nearest segment projector: tracks the segment table, predicts answers, compares.
module nearest_segment_projector_checker
    import nsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  nsp_req_t    request,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        done,
    input  nsp_rsp_t    result,
    output int          errors,
    output int          pending,
    output int          answers_seen,
    output int          matches_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;

    int          start_x [TABLE_DEPTH];
    int          start_y [TABLE_DEPTH];
    int          end_x   [TABLE_DEPTH];
    int          end_y   [TABLE_DEPTH];
    int          stored;
    logic [31:0] limit_reg;
    nsp_rsp_t    answers_due [$];

    // Rounded offset of the foot along one axis, halves away from zero.
    function automatic longint foot_offset(longint d, logic signed [127:0] dot,
                                           logic signed [127:0] len);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        begin
            mag = (d < 0) ? -d : d;
            q   = (2 * (dot * mag) + len) / (2 * len);
            foot_offset = (d < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic nsp_rsp_t nearest_match(int px, int py);
        logic signed [127:0] lim2, best, dx, dy, wx, wy, len, dot, ex, ey, dsq;
        longint              fx, fy;
        nsp_rsp_t            r;
        bit                  have;
        begin
            r    = '0;
            have = 0;
            best = 0;
            lim2 = $signed({96'b0, limit_reg}) * $signed({96'b0, limit_reg});
            for (int j = 0; j < stored; j++) begin
                dx = longint'(end_x[j]) - longint'(start_x[j]);
                dy = longint'(end_y[j]) - longint'(start_y[j]);
                if (dx == 0 && dy == 0)
                    continue;
                wx  = longint'(px) - longint'(start_x[j]);
                wy  = longint'(py) - longint'(start_y[j]);
                len = dx * dx + dy * dy;
                dot = wx * dx + wy * dy;
                if (dot < 0 || dot > len)
                    continue;
                fx  = longint'(start_x[j]) + foot_offset(longint'(dx), dot, len);
                fy  = longint'(start_y[j]) + foot_offset(longint'(dy), dot, len);
                ex  = longint'(px) - fx;
                ey  = longint'(py) - fy;
                dsq = ex * ex + ey * ey;
                if (dsq >= lim2 || (have && dsq >= best))
                    continue;
                have            = 1;
                best            = dsq;
                r.found         = 1'b1;
                r.segment_index = j[9:0];
                r.foot_x        = fx[31:0];
                r.foot_y        = fy[31:0];
                r.distance_sq   = (best >= (128'sd1 <<< 63)) ? '1 : best[62:0];
            end
            nearest_match = r;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        nsp_rsp_t due;
        if (!rst_n) begin
            stored       <= 0;
            limit_reg    <= 32'(BASE_LIMIT_METRES << 4);
            errors       <= 0;
            pending      <= 0;
            answers_seen <= 0;
            matches_seen <= 0;
            answers_due.delete();
        end
        else begin
            if (done) begin
                answers_seen <= answers_seen + 1;
                if (answers_due.size() == 0) begin
                    $error("answer with nothing outstanding");
                    errors <= errors + 1;
                end
                else begin
                    due = answers_due.pop_front();
                    if (due.found)
                        matches_seen <= matches_seen + 1;
                    if (due != result) begin
                        errors <= errors + 1;
                        if (due.found != result.found)
                            $error("found: expected %0d got %0d", due.found, result.found);
                        if (due.segment_index != result.segment_index)
                            $error("segment_index: expected %0d got %0d",
                                   due.segment_index, result.segment_index);
                        if (due.foot_x != result.foot_x)
                            $error("foot_x: expected %0d got %0d", due.foot_x, result.foot_x);
                        if (due.foot_y != result.foot_y)
                            $error("foot_y: expected %0d got %0d", due.foot_y, result.foot_y);
                        if (due.distance_sq != result.distance_sq)
                            $error("distance_sq: expected %0d got %0d",
                                   due.distance_sq, result.distance_sq);
                    end
                end
            end
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (start && !busy) begin
                case (request.action)
                    ACT_CLEAR: stored <= 0;
                    ACT_LOAD:
                        if (stored < TABLE_DEPTH) begin
                            start_x[stored] <= request.coord_ax;
                            start_y[stored] <= request.coord_ay;
                            end_x[stored]   <= request.coord_bx;
                            end_y[stored]   <= request.coord_by;
                            stored          <= stored + 1;
                        end
                    ACT_QUERY: answers_due = {answers_due,
                                              nearest_match(request.coord_ax,
                                                            request.coord_ay)};
                    default: ;
                endcase
            end
            pending <= answers_due.size();
        end
    end

endmodule

FILE: sim/nearest_segment_projector_tb.sv
// Testbench top for the nearest segment projector: request stimulus and verdict.
module nearest_segment_projector_tb;
    import nsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous: tables stay small, so even an all-query run stays well inside it.
    localparam int CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    nsp_req_t    request;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        done;
    nsp_rsp_t    result;
    int          errors;
    int          pending;
    int          answers_seen;
    int          matches_seen;
    int          cycles;
    int          requests_sent;
    int          gap_pct;

    nearest_segment_projector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    nearest_segment_projector_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .result       (result),
        .errors       (errors),
        .pending      (pending),
        .answers_seen (answers_seen),
        .matches_seen (matches_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost answer ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Present one request (called at a rising edge) and return at the edge that takes it.
    task automatic send(logic [1:0] act, int ax, int ay, int bx, int by);
        // sender idles cycle by cycle at the current gap rate
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start            <= 1'b1;
        request.action   <= act;
        request.coord_ax <= ax;
        request.coord_ay <= ay;
        request.coord_bx <= bx;
        request.coord_by <= by;
        // busy is looked at mid-cycle so the sample never races the edge
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        requests_sent++;
    endtask

    // Wait until every answer is back and the block is quiet.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    // Limit register changes only once every answer is back and the block is quiet.
    task automatic set_limit(logic [31:0] value);
        drain();
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int near_coord();
        near_coord = int'($urandom_range(0, 2000)) - 1000;
    endfunction

    function automatic int any_coord();
        any_coord = (($urandom_range(3) == 0) ? int'($urandom) : near_coord());
    endfunction

    // One road scene: fresh table, a few segments, a few points around them.
    task automatic random_scene();
        int n_seg;
        int n_pt;
        int x0;
        int y0;
        begin
            send(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
            n_seg = $urandom_range(1, 6);
            for (int k = 0; k < n_seg; k++)
            begin
                x0 = any_coord();
                y0 = any_coord();
                case ($urandom_range(4))
                    0: send(ACT_LOAD, x0, y0, x0, near_coord());     // vertical
                    1: send(ACT_LOAD, x0, y0, near_coord(), y0);     // horizontal
                    2: send(ACT_LOAD, x0, y0, x0, y0);               // zero length
                    default: send(ACT_LOAD, x0, y0, any_coord(), any_coord());
                endcase
            end
            n_pt = $urandom_range(1, 4);
            for (int k = 0; k < n_pt; k++)
                send(ACT_QUERY, any_coord(), any_coord(), $urandom, $urandom);
        end
    endtask

    task automatic random_phase(int pct, int quota);
        int first;
        begin
            gap_pct = pct;
            first   = requests_sent;
            while (requests_sent - first < quota)
            begin
                if ($urandom_range(9) < 8)
                    random_scene();
                else
                    // noise: any action including the unused code, full-range fields
                    send(2'($urandom), $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        clk       = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        gap_pct   = 0;
        requests_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, vertical and horizontal roads, zero-length, off-segment,
        // tie between identical roads, extreme coordinates, unused action code.
        send(ACT_QUERY, 5, 5, 0, 0);
        send(ACT_LOAD, 100, -100, 100, 300);
        send(ACT_LOAD, -50, 20, 250, 20);
        send(ACT_LOAD, 7, 7, 7, 7);
        send(ACT_LOAD, -50, 20, 250, 20);
        send(ACT_QUERY, 130, 80, 0, 0);
        send(ACT_QUERY, 100, 20, 0, 0);
        send(ACT_QUERY, 7, 7, 0, 0);
        send(ACT_QUERY, 900, 900, 0, 0);
        send(2'd3, -1, -1, -1, -1);
        send(ACT_QUERY, 33, -17, 0, 0);
        send(ACT_CLEAR, 0, 0, 0, 0);
        send(ACT_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send(ACT_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send(ACT_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
        send(ACT_QUERY, 0, 0, 0, 0);
        set_limit(32'hFFFF_FFFF);
        send(ACT_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
        send(ACT_QUERY, 12345, -54321, 0, 0);
        set_limit(32'd0);
        send(ACT_QUERY, 0, 0, 0, 0);
        set_limit(32'd3);
        send(ACT_CLEAR, 0, 0, 0, 0);
        send(ACT_LOAD, 0, 0, 10, 0);
        send(ACT_QUERY, 4, 2, 0, 0);
        send(ACT_QUERY, 4, 3, 0, 0);
        set_limit(32'd160000000);

        random_phase(27, 140);
        set_limit($urandom_range(50, 3000));
        random_phase(54, 140);
        set_limit($urandom);
        random_phase(0, 110);
        set_limit(32'hFFFF_FFFF);
        random_phase(0, 100);

        drain();
        repeat (20) @(posedge clk);

        $display("%0d requests sent, %0d answers checked, %0d with a matched road",
                 requests_sent, answers_seen, matches_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
design/nsp_pkg.sv
design/nsp_datapath.sv
design/nsp_controller.sv
design/nearest_segment_projector.sv
sim/nearest_segment_projector_checker.sv
sim/nearest_segment_projector_tb.sv
